### rtl/core/box_intersect_classify_unit_defines.svh
// Assertion macros for the box intersect classify unit.
`ifndef BOX_INTERSECT_CLASSIFY_UNIT_DEFINES_SVH
`define BOX_INTERSECT_CLASSIFY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BICU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BICU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`define BICU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define BICU_ASSERT(label, clk, rst_n, prop)
`define BICU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BICU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/bicu_pkg.sv
`default_nettype none

package bicu_pkg;

    localparam int COORD_W    = 32;
    localparam int TOL_W      = 31;
    localparam int EXT_W      = COORD_W + 1;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_MIN_X = 3'd0,
        REG_REF_MIN_Y = 3'd1,
        REG_REF_MIN_Z = 3'd2,
        REG_REF_MAX_X = 3'd3,
        REG_REF_MAX_Y = 3'd4,
        REG_REF_MAX_Z = 3'd5,
        REG_TOLERANCE = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        REL_DISJOINT = 2'd0,
        REL_OVERLAP  = 2'd1,
        REL_CONTAINS = 2'd2,
        REL_INSIDE   = 2'd3
    } relation_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EXT_W-1:0]   ext_t;
    typedef logic [TOL_W-1:0]          tol_t;

    // Reference bounds of one axis, with the tolerance already folded in.
    typedef struct packed {
        coord_t rmin;
        coord_t rmax;
        ext_t   rmin_pt;
        ext_t   rmin_mt;
        ext_t   rmax_pt;
        ext_t   rmax_mt;
    } axis_bounds_t;

    typedef struct packed {
        logic disjoint;
        logic contains;
        logic enclosed;
    } axis_flags_t;

endpackage

`default_nettype wire

### rtl/core/bicu_cfg.sv
`default_nettype none

module bicu_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bicu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bicu_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bicu_pkg::axis_bounds_t                   bounds [bicu_pkg::NUM_AXES]
);

    bicu_pkg::coord_t       ref_min_reg  [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       ref_min_next [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       ref_max_reg  [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       ref_max_next [bicu_pkg::NUM_AXES];
    bicu_pkg::tol_t         tol_reg;
    bicu_pkg::tol_t         tol_next;
    bicu_pkg::axis_bounds_t bounds_reg   [bicu_pkg::NUM_AXES];
    bicu_pkg::axis_bounds_t bounds_next  [bicu_pkg::NUM_AXES];
    bicu_pkg::ext_t         tol_ext;

    always_comb
    begin
        ref_min_next = ref_min_reg;
        ref_max_next = ref_max_reg;
        tol_next     = tol_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bicu_pkg::REG_REF_MIN_X: ref_min_next[0] = cfg_data;
                bicu_pkg::REG_REF_MIN_Y: ref_min_next[1] = cfg_data;
                bicu_pkg::REG_REF_MIN_Z: ref_min_next[2] = cfg_data;
                bicu_pkg::REG_REF_MAX_X: ref_max_next[0] = cfg_data;
                bicu_pkg::REG_REF_MAX_Y: ref_max_next[1] = cfg_data;
                bicu_pkg::REG_REF_MAX_Z: ref_max_next[2] = cfg_data;
                bicu_pkg::REG_TOLERANCE: tol_next = cfg_data[bicu_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Fold the tolerance into the bounds so each test is a single compare.
    assign tol_ext = {2'b00, tol_reg};

    always_comb
    begin
        for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
        begin
            bounds_next[a].rmin    = ref_min_reg[a];
            bounds_next[a].rmax    = ref_max_reg[a];
            bounds_next[a].rmin_pt = bicu_pkg::ext_t'(ref_min_reg[a]) + tol_ext;
            bounds_next[a].rmin_mt = bicu_pkg::ext_t'(ref_min_reg[a]) - tol_ext;
            bounds_next[a].rmax_pt = bicu_pkg::ext_t'(ref_max_reg[a]) + tol_ext;
            bounds_next[a].rmax_mt = bicu_pkg::ext_t'(ref_max_reg[a]) - tol_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
            begin
                ref_min_reg[a] <= '0;
                ref_max_reg[a] <= '0;
                bounds_reg[a]  <= '0;
            end
            tol_reg <= '0;
        end
        else
        begin
            ref_min_reg <= ref_min_next;
            ref_max_reg <= ref_max_next;
            tol_reg     <= tol_next;
            bounds_reg  <= bounds_next;
        end
    end

    assign bounds = bounds_reg;

endmodule

`default_nettype wire

### rtl/core/bicu_axis.sv
`default_nettype none

module bicu_axis (
    input  wire bicu_pkg::axis_bounds_t bounds,
    input  wire bicu_pkg::coord_t       cmin,
    input  wire bicu_pkg::coord_t       cmax,
    output bicu_pkg::axis_flags_t       flags,
    output bicu_pkg::coord_t            clip_min,
    output bicu_pkg::coord_t            clip_max
);

    bicu_pkg::ext_t cmin_ext;
    bicu_pkg::ext_t cmax_ext;

    assign cmin_ext = bicu_pkg::ext_t'(cmin);
    assign cmax_ext = bicu_pkg::ext_t'(cmax);

    // ref_max - in_min < -T  <=>  ref_max + T < in_min, and so on.
    assign flags.disjoint = (bounds.rmax_pt < cmin_ext) || (bounds.rmin_mt > cmax_ext);
    assign flags.contains = (bounds.rmax_mt > cmax_ext) && (bounds.rmin_pt < cmin_ext);
    assign flags.enclosed = (bounds.rmax < cmax) && (bounds.rmin_mt > cmin_ext);

    assign clip_min = (bounds.rmin > cmin) ? bounds.rmin : cmin;
    assign clip_max = (bounds.rmax < cmax) ? bounds.rmax : cmax;

endmodule

`default_nettype wire

### rtl/core/box_intersect_classify_unit.sv
// A request accepted into the input register is classified there and written into the result
// register when that register is free or drains; out_valid then shows the result.
// Throughput: one request per cycle while out_ready allows; each axis test is a single compare.
// Configuration writes pass through the configuration registers, then the registered bounds.
// Reset: asynchronous, active low; clears both valids and the configuration registers.
`default_nettype none

`include "box_intersect_classify_unit_defines.svh"

module box_intersect_classify_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bicu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bicu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [bicu_pkg::COORD_W-1:0] in_min_x,
    input  wire logic signed [bicu_pkg::COORD_W-1:0] in_min_y,
    input  wire logic signed [bicu_pkg::COORD_W-1:0] in_min_z,
    input  wire logic signed [bicu_pkg::COORD_W-1:0] in_max_x,
    input  wire logic signed [bicu_pkg::COORD_W-1:0] in_max_y,
    input  wire logic signed [bicu_pkg::COORD_W-1:0] in_max_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               relation,
    output logic signed [bicu_pkg::COORD_W-1:0]      out_min_x,
    output logic signed [bicu_pkg::COORD_W-1:0]      out_min_y,
    output logic signed [bicu_pkg::COORD_W-1:0]      out_min_z,
    output logic signed [bicu_pkg::COORD_W-1:0]      out_max_x,
    output logic signed [bicu_pkg::COORD_W-1:0]      out_max_y,
    output logic signed [bicu_pkg::COORD_W-1:0]      out_max_z
);

    bicu_pkg::axis_bounds_t bounds    [bicu_pkg::NUM_AXES];
    bicu_pkg::axis_flags_t  flags     [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       clip_min  [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       clip_max  [bicu_pkg::NUM_AXES];

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    bicu_pkg::coord_t       s1_min_reg [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       s1_max_reg [bicu_pkg::NUM_AXES];

    logic                   out_valid_reg;
    logic                   out_valid_next;
    bicu_pkg::relation_t    relation_reg;
    bicu_pkg::relation_t    relation_next;
    bicu_pkg::coord_t       out_min_reg  [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       out_min_next [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       out_max_reg  [bicu_pkg::NUM_AXES];
    bicu_pkg::coord_t       out_max_next [bicu_pkg::NUM_AXES];

    logic [bicu_pkg::NUM_AXES-1:0] dis_v;
    logic [bicu_pkg::NUM_AXES-1:0] con_v;
    logic [bicu_pkg::NUM_AXES-1:0] ins_v;
    logic                          adv;
    logic                          in_fire;

    bicu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bounds    (bounds)
    );

    for (genvar a = 0; a < bicu_pkg::NUM_AXES; a++)
    begin : g_axis
        bicu_axis u_axis (
            .bounds   (bounds[a]),
            .cmin     (s1_min_reg[a]),
            .cmax     (s1_max_reg[a]),
            .flags    (flags[a]),
            .clip_min (clip_min[a]),
            .clip_max (clip_max[a])
        );
        assign dis_v[a] = flags[a].disjoint;
        assign con_v[a] = flags[a].contains;
        assign ins_v[a] = flags[a].enclosed;
    end

    // Advance stage 1 into the result register whenever that register is free or drains.
    assign adv     = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
    assign out_valid_next = adv ? s1_valid_reg : out_valid_reg;

    always_comb
    begin
        if (|dis_v)
            relation_next = bicu_pkg::REL_DISJOINT;
        else if (&con_v)
            relation_next = bicu_pkg::REL_CONTAINS;
        else if (&ins_v)
            relation_next = bicu_pkg::REL_INSIDE;
        else
            relation_next = bicu_pkg::REL_OVERLAP;

        for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
        begin
            if (relation_next == bicu_pkg::REL_OVERLAP)
            begin
                out_min_next[a] = clip_min[a];
                out_max_next[a] = clip_max[a];
            end
            else
            begin
                out_min_next[a] = '0;
                out_max_next[a] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_min_reg[0] <= in_min_x;
            s1_min_reg[1] <= in_min_y;
            s1_min_reg[2] <= in_min_z;
            s1_max_reg[0] <= in_max_x;
            s1_max_reg[1] <= in_max_y;
            s1_max_reg[2] <= in_max_z;
        end
        if (adv && s1_valid_reg)
        begin
            relation_reg <= relation_next;
            out_min_reg  <= out_min_next;
            out_max_reg  <= out_max_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign relation  = relation_reg;
    assign out_min_x = out_min_reg[0];
    assign out_min_y = out_min_reg[1];
    assign out_min_z = out_min_reg[2];
    assign out_max_x = out_max_reg[0];
    assign out_max_y = out_max_reg[1];
    assign out_max_z = out_max_reg[2];

    `BICU_ASSERT_IMPL(a_coords_zero, clk, rst_n, out_valid_reg && (relation_reg != bicu_pkg::REL_OVERLAP), (out_min_reg[0] == '0) && (out_max_reg[0] == '0) && (out_min_reg[1] == '0) && (out_max_reg[1] == '0) && (out_min_reg[2] == '0) && (out_max_reg[2] == '0))
    `BICU_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid_reg, in_ready)
    `BICU_ASSERT_NEXT(a_s1_moves_out, clk, rst_n, s1_valid_reg && adv, out_valid_reg)
    `BICU_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !adv, s1_valid_reg && $stable(s1_min_reg[0]) && $stable(s1_max_reg[2]))

endmodule

`default_nettype wire

### verif/box_intersect_classify_unit_tb.sv
`default_nettype none

module box_intersect_classify_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bicu_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam bicu_pkg::coord_t COORD_FLOOR = bicu_pkg::coord_t'(32'h8000_0000);
    localparam bicu_pkg::coord_t COORD_CEIL  = bicu_pkg::coord_t'(32'h7FFF_FFFF);
    localparam int     RUN_LIMIT     = 200000;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_BOXES   = 125;
    localparam int     MAX_REPORTS   = 10;

    localparam bicu_pkg::reg_idx_t MIN_REGS [bicu_pkg::NUM_AXES] =
        '{bicu_pkg::REG_REF_MIN_X, bicu_pkg::REG_REF_MIN_Y, bicu_pkg::REG_REF_MIN_Z};
    localparam bicu_pkg::reg_idx_t MAX_REGS [bicu_pkg::NUM_AXES] =
        '{bicu_pkg::REG_REF_MAX_X, bicu_pkg::REG_REF_MAX_Y, bicu_pkg::REG_REF_MAX_Z};

    typedef struct {
        bicu_pkg::coord_t lo [bicu_pkg::NUM_AXES];
        bicu_pkg::coord_t hi [bicu_pkg::NUM_AXES];
    } box_t;

    typedef struct {
        bicu_pkg::relation_t rel;
        bicu_pkg::coord_t    lo [bicu_pkg::NUM_AXES];
        bicu_pkg::coord_t    hi [bicu_pkg::NUM_AXES];
    } verdict_t;

    typedef enum int {
        SHAPE_CONTAINED,
        SHAPE_ENCLOSING,
        SHAPE_STRADDLE,
        SHAPE_APART,
        SHAPE_NOISE,
        SHAPE_EXTREME
    } shape_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SLOW,
        SINK_BEAT
    } sink_mode_t;

    class box_relation_board;
        bicu_pkg::coord_t ref_lo [bicu_pkg::NUM_AXES];
        bicu_pkg::coord_t ref_hi [bicu_pkg::NUM_AXES];
        bicu_pkg::tol_t   tol;
        verdict_t         verdicts_due [$];
        int               faults;

        function new();
            for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
            begin
                ref_lo[a] = '0;
                ref_hi[a] = '0;
            end
            tol = '0;
            faults = 0;
        endfunction

        function void set_reg(logic [bicu_pkg::CFG_IDX_W-1:0] idx,
                              logic [bicu_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bicu_pkg::REG_REF_MIN_X: ref_lo[0] = data;
                bicu_pkg::REG_REF_MIN_Y: ref_lo[1] = data;
                bicu_pkg::REG_REF_MIN_Z: ref_lo[2] = data;
                bicu_pkg::REG_REF_MAX_X: ref_hi[0] = data;
                bicu_pkg::REG_REF_MAX_Y: ref_hi[1] = data;
                bicu_pkg::REG_REF_MAX_Z: ref_hi[2] = data;
                bicu_pkg::REG_TOLERANCE: tol = data[bicu_pkg::TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function verdict_t classify_box(box_t c);
            verdict_t       v;
            bicu_pkg::ext_t t;
            logic           apart;
            logic           holds;
            logic           held;
            t = bicu_pkg::ext_t'({2'b00, tol});
            apart = 1'b0;
            holds = 1'b1;
            held = 1'b1;
            for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
            begin
                bicu_pkg::ext_t rlo;
                bicu_pkg::ext_t rhi;
                bicu_pkg::ext_t clo;
                bicu_pkg::ext_t chi;
                rlo = bicu_pkg::ext_t'(ref_lo[a]);
                rhi = bicu_pkg::ext_t'(ref_hi[a]);
                clo = bicu_pkg::ext_t'(c.lo[a]);
                chi = bicu_pkg::ext_t'(c.hi[a]);
                if (rhi - clo < -t || rlo - chi > t)
                    apart = 1'b1;
                if (!(rhi - chi > t && rlo - clo < -t))
                    holds = 1'b0;
                if (!(rhi < chi && rlo - clo > t))
                    held = 1'b0;
                v.lo[a] = '0;
                v.hi[a] = '0;
            end
            if (apart)
                v.rel = bicu_pkg::REL_DISJOINT;
            else if (holds)
                v.rel = bicu_pkg::REL_CONTAINS;
            else if (held)
                v.rel = bicu_pkg::REL_INSIDE;
            else
            begin
                v.rel = bicu_pkg::REL_OVERLAP;
                for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
                begin
                    v.lo[a] = (ref_lo[a] > c.lo[a]) ? ref_lo[a] : c.lo[a];
                    v.hi[a] = (ref_hi[a] < c.hi[a]) ? ref_hi[a] : c.hi[a];
                end
            end
            return v;
        endfunction

        function void note_box(box_t c);
            verdicts_due.push_back(classify_box(c));
        endfunction

        function string show(verdict_t v);
            return $sformatf("rel=%0d lo=%h,%h,%h hi=%h,%h,%h", v.rel,
                             v.lo[0], v.lo[1], v.lo[2], v.hi[0], v.hi[1], v.hi[2]);
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            logic     same;
            if (verdicts_due.size() == 0)
            begin
                note_fault($sformatf("unexpected result: %s", show(got)));
                return;
            end
            want = verdicts_due.pop_front();
            same = (want.rel === got.rel);
            for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
                same &= (want.lo[a] === got.lo[a]) && (want.hi[a] === got.hi[a]);
            if (!same)
                note_fault($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
        endfunction

        function void close();
            if (verdicts_due.size() != 0)
                note_fault($sformatf("%0d results never came", verdicts_due.size()));
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [bicu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bicu_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    bicu_pkg::coord_t                in_min_x = '0;
    bicu_pkg::coord_t                in_min_y = '0;
    bicu_pkg::coord_t                in_min_z = '0;
    bicu_pkg::coord_t                in_max_x = '0;
    bicu_pkg::coord_t                in_max_y = '0;
    bicu_pkg::coord_t                in_max_z = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [1:0]                      relation;
    bicu_pkg::coord_t                out_min_x;
    bicu_pkg::coord_t                out_min_y;
    bicu_pkg::coord_t                out_min_z;
    bicu_pkg::coord_t                out_max_x;
    bicu_pkg::coord_t                out_max_y;
    bicu_pkg::coord_t                out_max_z;

    sink_mode_t                      sink_mode = SINK_OPEN;
    int                              sink_hold = 0;
    int                              sink_tick = 0;
    int                              cycles = 0;

    box_relation_board               board;

    box_intersect_classify_unit dut (.*);

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (sink_hold == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            sink_hold <= $urandom_range(16, 160);
        end
        else
        begin
            sink_hold <= sink_hold - 1;
        end
        sink_tick <= sink_tick + 1;
        case (sink_mode)
            SINK_OPEN: out_ready <= 1'b1;
            SINK_COIN: out_ready <= ($urandom_range(0, 1) != 0);
            SINK_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= (sink_tick % 8 < 5);
        endcase
    end

    always @(posedge clk)
    begin
        verdict_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.rel   = bicu_pkg::relation_t'(relation);
            got.lo[0] = out_min_x;
            got.lo[1] = out_min_y;
            got.lo[2] = out_min_z;
            got.hi[0] = out_max_x;
            got.hi[1] = out_max_y;
            got.hi[2] = out_max_z;
            board.check_result(got);
        end
    end

    initial
    begin
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("box_intersect_classify_unit_tb: FAIL");
        $finish;
    end

    task automatic drive_box(box_t b);
        @(negedge clk);
        in_valid = 1'b1;
        in_min_x = b.lo[0];
        in_min_y = b.lo[1];
        in_min_z = b.lo[2];
        in_max_x = b.hi[0];
        in_max_y = b.hi[1];
        in_max_z = b.hi[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_box(b);
    endtask

    task automatic pause_input(int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [bicu_pkg::CFG_IDX_W-1:0] idx,
                             logic [bicu_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic close_writes();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_reference(box_t r, logic [bicu_pkg::CFG_DATA_W-1:0] tol_word);
        for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
        begin
            write_reg(MIN_REGS[a], r.lo[a]);
            write_reg(MAX_REGS[a], r.hi[a]);
        end
        write_reg(bicu_pkg::REG_TOLERANCE, tol_word);
        close_writes();
    endtask

    function automatic int margin();
        case ($urandom_range(0, 7))
            0: return -1;
            1: return 0;
            2: return 1;
            default: return int'($urandom_range(1, 1 << 16));
        endcase
    endfunction

    function automatic int jitter();
        return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    function automatic bicu_pkg::coord_t extreme();
        case ($urandom_range(0, 4))
            0: return COORD_FLOOR;
            1: return COORD_CEIL;
            2: return '0;
            3: return '1;
            default: return bicu_pkg::coord_t'(1);
        endcase
    endfunction

    // Shift every face of the reference by a pad; positive pads move inward.
    function automatic box_t frame(int lo_pad, int hi_pad);
        box_t b;
        for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
        begin
            b.lo[a] = bicu_pkg::coord_t'(int'(board.ref_lo[a]) + lo_pad);
            b.hi[a] = bicu_pkg::coord_t'(int'(board.ref_hi[a]) - hi_pad);
        end
        return b;
    endfunction

    function automatic box_t random_box();
        box_t   b;
        shape_t shape;
        int     pick;
        int     t;
        int     ax;
        pick = $urandom_range(0, 99);
        shape = pick < 20 ? SHAPE_CONTAINED :
                pick < 40 ? SHAPE_ENCLOSING :
                pick < 60 ? SHAPE_STRADDLE :
                pick < 80 ? SHAPE_APART :
                pick < 92 ? SHAPE_NOISE : SHAPE_EXTREME;
        t = int'(board.tol);
        ax = $urandom_range(0, bicu_pkg::NUM_AXES - 1);
        for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
        begin
            int rlo;
            int rhi;
            rlo = board.ref_lo[a];
            rhi = board.ref_hi[a];
            case (shape)
                SHAPE_CONTAINED:
                begin
                    b.lo[a] = bicu_pkg::coord_t'(rlo + t + margin());
                    b.hi[a] = bicu_pkg::coord_t'(rhi - t - margin());
                end
                SHAPE_ENCLOSING:
                begin
                    b.lo[a] = bicu_pkg::coord_t'(rlo - t - margin());
                    b.hi[a] = bicu_pkg::coord_t'(rhi + margin());
                end
                SHAPE_NOISE:
                begin
                    b.lo[a] = $urandom;
                    b.hi[a] = $urandom;
                end
                SHAPE_EXTREME:
                begin
                    b.lo[a] = extreme();
                    b.hi[a] = extreme();
                end
                default:
                begin
                    b.lo[a] = bicu_pkg::coord_t'(rlo + jitter());
                    b.hi[a] = bicu_pkg::coord_t'(rhi + jitter());
                end
            endcase
            // push one axis to the edge of the tolerance band or beyond, on either side
            if (shape == SHAPE_APART && a == ax)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    b.lo[a] = bicu_pkg::coord_t'(rhi + t + margin());
                    b.hi[a] = bicu_pkg::coord_t'(int'(b.lo[a]) +
                                                 int'($urandom_range(0, 1 << 16)));
                end
                else
                begin
                    b.hi[a] = bicu_pkg::coord_t'(rlo - t - margin());
                    b.lo[a] = bicu_pkg::coord_t'(int'(b.hi[a]) -
                                                 int'($urandom_range(0, 1 << 16)));
                end
            end
        end
        return b;
    endfunction

    function automatic box_t random_reference();
        box_t             r;
        int               mid;
        int               half;
        bicu_pkg::coord_t spare;
        for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
        begin
            mid = $urandom;
            case ($urandom_range(0, 3))
                0: half = $urandom_range(0, 4);
                1: half = $urandom_range(1 << 24, 1 << 30);
                default: half = $urandom_range(1 << 16, 1 << 24);
            endcase
            r.lo[a] = bicu_pkg::coord_t'(mid - half);
            r.hi[a] = bicu_pkg::coord_t'(mid + half);
            if ($urandom_range(0, 9) == 0)
            begin
                spare = r.lo[a];
                r.lo[a] = r.hi[a];
                r.hi[a] = spare;
            end
        end
        return r;
    endfunction

    function automatic logic [bicu_pkg::CFG_DATA_W-1:0] random_tol_word();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 32'h0001_0000;
            2: return 32'($urandom_range(0, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_extremes();
        box_t             b;
        bicu_pkg::coord_t lo_vals [5] = '{COORD_FLOOR, COORD_CEIL, COORD_FLOOR, COORD_CEIL, '0};
        bicu_pkg::coord_t hi_vals [5] = '{COORD_FLOOR, COORD_CEIL, COORD_CEIL, COORD_FLOOR, '1};
        for (int k = 0; k < 5; k++)
        begin
            for (int a = 0; a < bicu_pkg::NUM_AXES; a++)
            begin
                b.lo[a] = lo_vals[k];
                b.hi[a] = hi_vals[k];
            end
            drive_box(b);
        end
    endtask

    task automatic send_edges();
        box_t b;
        int   t;
        t = int'(board.tol);
        drive_box(frame(t + 1, t + 1));
        drive_box(frame(t, t + 1));
        drive_box(frame(-t - 1, -1));
        drive_box(frame(-t - 1, 0));
        drive_box(frame(-t, -1));
        b = frame(0, 0);
        b.lo[0] = bicu_pkg::coord_t'(int'(board.ref_hi[0]) + t + 1);
        b.hi[0] = bicu_pkg::coord_t'(int'(b.lo[0]) + 5);
        drive_box(b);
        b.lo[0] = bicu_pkg::coord_t'(int'(b.lo[0]) - 1);
        drive_box(b);
        b = frame(0, 0);
        b.hi[2] = bicu_pkg::coord_t'(int'(board.ref_lo[2]) - t - 1);
        b.lo[2] = bicu_pkg::coord_t'(int'(b.hi[2]) - 3);
        drive_box(b);
        b.hi[2] = bicu_pkg::coord_t'(int'(b.hi[2]) + 1);
        drive_box(b);
        // swapped x faces: clipped box comes out inverted
        b = frame(0, 0);
        b.lo[0] = board.ref_hi[0];
        b.hi[0] = board.ref_lo[0];
        drive_box(b);
    endtask

    initial
    begin
        box_t r;
        int   burst_left;
        burst_left = 0;
        board = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_extremes();
        drain();

        r.lo[0] = -655360;
        r.hi[0] = 655360;
        r.lo[1] = -262144;
        r.hi[1] = 393216;
        r.lo[2] = 131072;
        r.hi[2] = 2621440;
        load_reference(r, 32'h0001_0000);
        send_edges();
        send_extremes();
        drain();

        // widest, inverted and degenerate axes, tolerance word with its top bit set
        r.lo[0] = COORD_FLOOR;
        r.hi[0] = COORD_CEIL;
        r.lo[1] = COORD_CEIL;
        r.hi[1] = COORD_FLOOR;
        r.lo[2] = '0;
        r.hi[2] = '0;
        load_reference(r, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'h1234_5678);
        close_writes();
        send_extremes();
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_reference(random_reference(), random_tol_word());
            for (int i = 0; i < PHASE_BOXES; i++)
            begin
                if (burst_left == 0)
                begin
                    if (p != 2)
                        pause_input($urandom_range(0, 6));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                // hold the sender until every pending request has its result
                if (p == 4 && i == PHASE_BOXES / 2)
                    drain();
                drive_box(random_box());
            end
            drain();
        end

        repeat (8) @(posedge clk);
        board.close();
        if (board.faults == 0)
            $display("box_intersect_classify_unit_tb: PASS");
        else
            $display("box_intersect_classify_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/bicu_pkg.sv
rtl/core/bicu_cfg.sv
rtl/core/bicu_axis.sv
rtl/core/box_intersect_classify_unit.sv
verif/box_intersect_classify_unit_tb.sv
